>>> rtl/lsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types and constants of the learning switch forwarder: walk record
// handed from cell to cell, table write bundle, result codes, register map.
// ----------------------------------------------------------------------------
package lsf_pkg;

   // default sizes
   localparam int LSF_TABLE_ENTRIES = 16;
   localparam int LSF_MAX_PORTS     = 6;

   // fixed field widths
   localparam int LSF_MAC_W    = 48;
   localparam int LSF_PORT_W   = 3;
   localparam int LSF_LEN_W    = 14;
   localparam int LSF_STAMP_W  = 32;
   localparam int LSF_MASK_W   = 6;
   localparam int LSF_OWN_MACS = 6;
   localparam int LSF_GROUP_BIT = 40;
   localparam logic [LSF_LEN_W-1:0] LSF_MIN_FRAME = 14'd14;

   // entry index carried in the walk record, wide enough for the largest table
   localparam int LSF_IDX_W = 10;

   // register map
   localparam logic [2:0] CSR_PORT_COUNT = 3'd0;
   localparam logic [2:0] CSR_OWN_MAC1   = 3'd1;
   localparam logic [2:0] CSR_OWN_MAC6   = 3'd6;

   typedef enum logic [2:0] {
      ACT_REFRESH  = 3'd0,
      ACT_INSERT   = 3'd1,
      ACT_REPLACE  = 3'd2,
      ACT_OWN_SKIP = 3'd3,
      ACT_NONE     = 3'd4
   } lsf_action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_MALFORMED = 2'd1,
      ST_BAD_PORT  = 2'd2
   } lsf_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FINISH
   } lsf_state_type;

   // record that travels down the chain, one cell per cycle
   typedef struct packed {
      logic                   valid;
      logic                   src_hit;
      logic [LSF_IDX_W-1:0]   src_idx;
      logic                   dst_hit;
      logic [LSF_IDX_W-1:0]   dst_idx;
      logic [LSF_PORT_W-1:0]  dst_port;
      logic                   old_have;
      logic [LSF_IDX_W-1:0]   old_idx;
      logic [LSF_STAMP_W-1:0] old_stamp;
   } lsf_walk_type;

   // table write broadcast to every cell
   typedef struct packed {
      logic                   en;
      logic [LSF_IDX_W-1:0]   idx;
      logic [LSF_MAC_W-1:0]   mac;
      logic [LSF_PORT_W-1:0]  port;
      logic [LSF_STAMP_W-1:0] stamp;
   } lsf_wr_type;

endpackage

>>> rtl/lsf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_cell
// One table entry. Holds mac, port and stamp, matches the passing walk record
// against the source and destination keys and keeps the oldest-stamp search.
// ----------------------------------------------------------------------------
module lsf_cell
   import lsf_pkg::*;
#(
   parameter int CELL_IDX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lsf_walk_type           walk_in,
   input  logic [LSF_MAC_W-1:0]   src_mac,
   input  logic [LSF_MAC_W-1:0]   dst_mac,
   input  logic                   used,
   input  lsf_wr_type             wr,
   output lsf_walk_type           walk_out
);

   localparam logic [LSF_IDX_W-1:0] MY_IDX = LSF_IDX_W'(CELL_IDX);

   logic [LSF_MAC_W-1:0]   mac_ff;
   logic [LSF_PORT_W-1:0]  port_ff;
   logic [LSF_STAMP_W-1:0] stamp_ff;
   lsf_walk_type           walk_ff;
   lsf_walk_type           walk_in_next;

   // entry storage, written by index match
   always_ff @(posedge clock) begin
      if (wr.en && wr.idx == MY_IDX) begin
         mac_ff   <= wr.mac;
         port_ff  <= wr.port;
         stamp_ff <= wr.stamp;
      end
   end

   // fold this entry into the passing record
   always_comb begin
      walk_in_next = walk_in;
      if (used) begin
         if (!walk_in.src_hit && mac_ff == src_mac) begin
            walk_in_next.src_hit = 1'b1;
            walk_in_next.src_idx = MY_IDX;
         end
         if (!walk_in.dst_hit && mac_ff == dst_mac) begin
            walk_in_next.dst_hit  = 1'b1;
            walk_in_next.dst_idx  = MY_IDX;
            walk_in_next.dst_port = port_ff;
         end
         // strict compare keeps the lowest index on a tie
         if (!walk_in.old_have || stamp_ff < walk_in.old_stamp) begin
            walk_in_next.old_have  = 1'b1;
            walk_in_next.old_idx   = MY_IDX;
            walk_in_next.old_stamp = stamp_ff;
         end
      end
   end

   // hand the record to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff.valid <= 1'b0;
      end else begin
         walk_ff.valid <= walk_in_next.valid;
      end
      walk_ff.src_hit   <= walk_in_next.src_hit;
      walk_ff.src_idx   <= walk_in_next.src_idx;
      walk_ff.dst_hit   <= walk_in_next.dst_hit;
      walk_ff.dst_idx   <= walk_in_next.dst_idx;
      walk_ff.dst_port  <= walk_in_next.dst_port;
      walk_ff.old_have  <= walk_in_next.old_have;
      walk_ff.old_idx   <= walk_in_next.old_idx;
      walk_ff.old_stamp <= walk_in_next.old_stamp;
   end

   assign walk_out = walk_ff;

endmodule

>>> rtl/learning_switch_forwarder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// learning_switch_forwarder_core
// Learning switch forwarding decision: source learning with oldest-stamp
// eviction and destination lookup over a chain of table cells.
//
//   channel  direction  handshake          contents
//   req_     in         valid / stall      ingress port, macs, length, stamp
//   rsp_     out        valid / stall      port mask, flooded, action, status
//   csr_     in         valid / ready      register index, write data
//
// A request walks the cell chain one cell per cycle. A good header is captured,
// launched, caught at the tail and loaded into the output register; a dropped
// header skips the walk. The next request is taken once the result sits in the
// output register, even while rsp_stall holds it. Synchronous reset empties the
// table (fill count to zero) and loads port_count 6 and own macs 0.
// ----------------------------------------------------------------------------
module learning_switch_forwarder_core
   import lsf_pkg::*;
#(
   parameter int TABLE_ENTRIES = LSF_TABLE_ENTRIES,
   parameter int MAX_PORTS     = LSF_MAX_PORTS
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [LSF_PORT_W-1:0]  req_in_port,
   input  logic [LSF_MAC_W-1:0]   req_src_mac,
   input  logic [LSF_MAC_W-1:0]   req_dst_mac,
   input  logic [LSF_LEN_W-1:0]   req_frame_length,
   input  logic [LSF_STAMP_W-1:0] req_now_stamp,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [LSF_MASK_W-1:0]  rsp_port_mask,
   output logic                   rsp_flooded,
   output logic [2:0]             rsp_learn_action,
   output logic [1:0]             rsp_status,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [LSF_MAC_W-1:0]   csr_wdata
);

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);
   localparam logic [LSF_PORT_W-1:0] MAX_P = LSF_PORT_W'(MAX_PORTS);

   // registers
   lsf_state_type          state_ff, state_in;
   logic [LSF_PORT_W-1:0]  port_count_ff;
   logic [LSF_MAC_W-1:0]   own_mac_ff [LSF_OWN_MACS];
   logic [CNT_W-1:0]       count_ff;
   logic                   launch_ff;
   logic [LSF_PORT_W-1:0]  port_ff;
   logic [LSF_MAC_W-1:0]   src_ff;
   logic [LSF_MAC_W-1:0]   dst_ff;
   logic [LSF_STAMP_W-1:0] stamp_ff;
   logic                   own_ff;
   lsf_status_type         status_ff, status_in;
   logic [LSF_PORT_W-1:0]  nports_ff;
   lsf_walk_type           tail_ff;
   logic                   rsp_valid_ff;
   logic [LSF_MASK_W-1:0]  rsp_mask_ff;
   logic                   rsp_flooded_ff;
   lsf_action_type         rsp_action_ff;
   lsf_status_type         rsp_status_ff;

   // combinational
   logic [LSF_PORT_W-1:0]  nports;
   logic                   own_hit;
   logic                   accept;
   logic                   load_rsp;
   lsf_action_type         action;
   logic [LSF_IDX_W-1:0]   wr_idx;
   logic                   self_hit;
   logic                   dst_known;
   logic [LSF_PORT_W-1:0]  dst_port;
   logic [LSF_MASK_W-1:0]  mask;
   logic                   flooded;
   lsf_wr_type             wr;
   lsf_walk_type           walk [TABLE_ENTRIES+1];
   logic [TABLE_ENTRIES-1:0] used;

   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         port_count_ff <= 3'd6;
         for (int i = 0; i < LSF_OWN_MACS; i++) begin
            own_mac_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index) inside
            CSR_PORT_COUNT: port_count_ff <= csr_wdata[LSF_PORT_W-1:0];
            [CSR_OWN_MAC1:CSR_OWN_MAC6]:
               own_mac_ff[3'(csr_index - CSR_OWN_MAC1)] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // active port count, clamped to one .. MAX_PORTS
   always_comb begin
      nports = port_count_ff;
      if (nports == '0) begin
         nports = 3'd1;
      end
      if (nports > MAX_P) begin
         nports = MAX_P;
      end
   end

   // own mac match over the active ports
   always_comb begin
      own_hit = 1'b0;
      for (int i = 0; i < LSF_OWN_MACS; i++) begin
         if (LSF_PORT_W'(i + 1) <= nports && own_mac_ff[i] == req_src_mac) begin
            own_hit = 1'b1;
         end
      end
   end

   assign accept   = req_valid && !req_stall;
   assign load_rsp = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // header checks, port before length
   always_comb begin
      if (req_in_port == '0 || req_in_port > nports) begin
         status_in = ST_BAD_PORT;
      end else if (req_frame_length < LSF_MIN_FRAME) begin
         status_in = ST_MALFORMED;
      end else begin
         status_in = ST_OK;
      end
   end

   // cell chain
   always_comb begin
      walk[0]           = '0;
      walk[0].valid     = launch_ff;
      walk[0].old_stamp = '1;
   end

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      assign used[g] = CNT_W'(g) < count_ff;
      lsf_cell #(
         .CELL_IDX (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .walk_in  (walk[g]),
         .src_mac  (src_ff),
         .dst_mac  (dst_ff),
         .used     (used[g]),
         .wr       (wr),
         .walk_out (walk[g+1])
      );
   end

   // learning decision from the finished walk
   always_comb begin
      wr_idx = tail_ff.src_idx;
      if (own_ff) begin
         action = ACT_OWN_SKIP;
      end else if (tail_ff.src_hit) begin
         action = ACT_REFRESH;
      end else if (count_ff == FULL_COUNT) begin
         action = ACT_REPLACE;
         wr_idx = tail_ff.old_idx;
      end else begin
         action = ACT_INSERT;
         wr_idx = LSF_IDX_W'(count_ff);
      end
   end

   assign wr.en    = load_rsp && status_ff == ST_OK && action != ACT_OWN_SKIP;
   assign wr.idx   = wr_idx;
   assign wr.mac   = src_ff;
   assign wr.port  = port_ff;
   assign wr.stamp = stamp_ff;

   // forwarding against the table as it stands after learning
   always_comb begin
      self_hit  = !dst_ff[LSF_GROUP_BIT] && action != ACT_OWN_SKIP && dst_ff == src_ff;
      dst_known = !dst_ff[LSF_GROUP_BIT] && (self_hit || (tail_ff.dst_hit &&
                  !(action == ACT_REPLACE && tail_ff.dst_idx == wr_idx)));
      dst_port  = self_hit ? port_ff : tail_ff.dst_port;
      flooded   = !dst_known;
      for (int i = 0; i < LSF_MASK_W; i++) begin
         if (dst_known) begin
            mask[i] = dst_port == LSF_PORT_W'(i + 1);
         end else begin
            mask[i] = LSF_PORT_W'(i + 1) <= nports_ff && LSF_PORT_W'(i + 1) != port_ff;
         end
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = (status_in == ST_OK) ? S_WALK : S_FINISH;
            end
         end
         S_WALK: begin
            if (walk[TABLE_ENTRIES].valid) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // request capture and walk launch
   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff <= 1'b0;
      end else begin
         launch_ff <= accept && status_in == ST_OK;
      end
      if (accept) begin
         port_ff   <= req_in_port;
         src_ff    <= req_src_mac;
         dst_ff    <= req_dst_mac;
         stamp_ff  <= req_now_stamp;
         own_ff    <= own_hit;
         status_ff <= status_in;
         nports_ff <= nports;
      end
      if (walk[TABLE_ENTRIES].valid) begin
         tail_ff <= walk[TABLE_ENTRIES];
      end
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (wr.en && action == ACT_INSERT) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= load_rsp || (rsp_valid_ff && rsp_stall);
      end
      if (load_rsp) begin
         rsp_status_ff <= status_ff;
         if (status_ff == ST_OK) begin
            rsp_mask_ff    <= mask;
            rsp_flooded_ff <= flooded;
            rsp_action_ff  <= action;
         end else begin
            rsp_mask_ff    <= '0;
            rsp_flooded_ff <= 1'b0;
            rsp_action_ff  <= ACT_NONE;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_port_mask    = rsp_mask_ff;
   assign rsp_flooded      = rsp_flooded_ff;
   assign rsp_learn_action = rsp_action_ff;
   assign rsp_status       = rsp_status_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fill count beyond table size");

   a_tail_in_walk: assert property (@(posedge clock) disable iff (reset)
      walk[TABLE_ENTRIES].valid |-> state_ff == S_WALK)
      else $error("walk record left the chain outside a walk");

   a_write_on_good: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> state_ff == S_FINISH && status_ff == ST_OK)
      else $error("table write without a good request");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      wr.en && action == ACT_INSERT |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the table");

endmodule
